>>> design/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// Used by u8u16_step, u8u16_fifo and utf8_to_utf16_decoder_unit; no dependencies.
package u8u16_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    StUnit    = 2'd0,
    StError   = 2'd1,
    StTextEnd = 2'd2
  } status_e;

  // One input request: a raw byte and the end-of-text flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_req_t;

  // One result item
  typedef struct packed {
    logic [15:0] code_unit;
    status_e     status;
    logic        last_of_item;
    logic        end_of_text;
  } out_rsp_t;

  // Results caused by one request: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    out_rsp_t   first;
    out_rsp_t   second;
  } step_res_t;

  localparam int unsigned FifoDepthDef = 4;

  localparam int unsigned PendW  = 3;
  localparam int unsigned AccumW = 32;

  localparam logic [PendW-1:0] MaxPending = 3'd5;

  // Byte class boundaries
  localparam logic [7:0] ContBase  = 8'h80;
  localparam logic [7:0] Lead2Base = 8'hC0;
  localparam logic [7:0] Lead3Base = 8'hE0;
  localparam logic [7:0] Lead4Base = 8'hF0;
  localparam logic [7:0] Lead5Base = 8'hF8;
  localparam logic [7:0] Lead6Base = 8'hFC;

  // Surrogate construction
  localparam logic [AccumW-1:0] SuppBase  = 32'h0001_0000;
  localparam logic [AccumW-1:0] SuppLimit = 32'h0010_0000;
  localparam logic [15:0]       HighSurr  = 16'hD800;
  localparam logic [15:0]       LowSurr   = 16'hDC00;

endpackage

>>> design/u8u16_step.sv
// Per-byte decode logic: next decoder state and up to two results.
// Purely combinational; depends on u8u16_pkg.
module u8u16_step (
  input  u8u16_pkg::in_req_t               req_i,
  input  logic [u8u16_pkg::PendW-1:0]      pend_i,
  input  logic [u8u16_pkg::AccumW-1:0]     accum_i,
  input  logic                             disc_i,
  output logic [u8u16_pkg::PendW-1:0]      pend_o,
  output logic [u8u16_pkg::AccumW-1:0]     accum_o,
  output logic                             disc_o,
  output u8u16_pkg::step_res_t             res_o
);
  import u8u16_pkg::*;

  logic [7:0]        b;
  logic              eot;
  logic              is_cont;
  logic [AccumW-1:0] shifted;
  logic [PendW-1:0]  pend_dec;
  logic [AccumW-1:0] supp;
  out_rsp_t          err_rsp;

  assign b        = req_i.in_byte;
  assign eot      = req_i.text_end;
  assign is_cont  = (b >= ContBase) && (b < Lead2Base);
  assign shifted  = {accum_i[AccumW-7:0], b[5:0]};
  assign pend_dec = pend_i - 1'b1;
  assign supp     = shifted - SuppBase;

  always_comb begin
    err_rsp.code_unit    = '0;
    err_rsp.status       = StError;
    err_rsp.last_of_item = 1'b1;
    err_rsp.end_of_text  = eot;
  end

  // Decode one byte against the current state
  always_comb begin
    pend_o       = pend_i;
    accum_o      = accum_i;
    disc_o       = disc_i;
    res_o.count  = 2'd0;
    res_o.first  = err_rsp;
    res_o.second = err_rsp;

    if (disc_i) begin
      // Drop bytes until the text ends, then report once
      if (eot) begin
        disc_o                   = 1'b0;
        res_o.count              = 2'd1;
        res_o.first.status       = StTextEnd;
        res_o.first.end_of_text  = 1'b1;
      end
    end else if (pend_i != '0) begin
      if (!is_cont || (pend_dec != '0 && eot)) begin
        pend_o      = '0;
        accum_o     = '0;
        disc_o      = !eot;
        res_o.count = 2'd1;
      end else if (pend_dec != '0) begin
        pend_o  = pend_dec;
        accum_o = shifted;
      end else begin
        // Sequence complete: one unit, a surrogate pair, or too large
        pend_o  = '0;
        accum_o = '0;
        if (shifted < SuppBase) begin
          res_o.count              = 2'd1;
          res_o.first.code_unit    = shifted[15:0];
          res_o.first.status       = StUnit;
        end else if (supp >= SuppLimit) begin
          disc_o      = !eot;
          res_o.count = 2'd1;
        end else begin
          res_o.count               = 2'd2;
          res_o.first.code_unit     = HighSurr + {6'd0, supp[19:10]};
          res_o.first.status        = StUnit;
          res_o.first.last_of_item  = 1'b0;
          res_o.first.end_of_text   = 1'b0;
          res_o.second.code_unit    = LowSurr + {6'd0, supp[9:0]};
          res_o.second.status       = StUnit;
        end
      end
    end else if (b < ContBase) begin
      // ASCII passes through
      res_o.count           = 2'd1;
      res_o.first.code_unit = {8'd0, b};
      res_o.first.status    = StUnit;
    end else if (b < Lead2Base) begin
      disc_o      = !eot;
      res_o.count = 2'd1;
    end else begin
      // Lead byte: load the value bits and the continuation count
      if (b < Lead3Base) begin
        pend_o  = 3'd1;
        accum_o = {27'd0, b[4:0]};
      end else if (b < Lead4Base) begin
        pend_o  = 3'd2;
        accum_o = {28'd0, b[3:0]};
      end else if (b < Lead5Base) begin
        pend_o  = 3'd3;
        accum_o = {29'd0, b[2:0]};
      end else if (b < Lead6Base) begin
        pend_o  = 3'd4;
        accum_o = {30'd0, b[1:0]};
      end else begin
        pend_o  = MaxPending;
        accum_o = {30'd0, b[1:0]};
      end
      if (eot) begin
        pend_o      = '0;
        accum_o     = '0;
        disc_o      = 1'b0;
        res_o.count = 2'd1;
      end
    end
  end

endmodule

>>> design/u8u16_fifo.sv
// Result queue: takes up to two results per cycle, gives one per ready cycle.
// Depends on u8u16_pkg.
module u8u16_fifo #(
  parameter int unsigned Depth = u8u16_pkg::FifoDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  u8u16_pkg::step_res_t  push_i,
  output logic                  space2_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output u8u16_pkg::out_rsp_t   out_rsp_o
);
  import u8u16_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_rsp_t         mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr1;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_rsp_o   = mem_q[rd_ptr_q];
  assign space2_o    = (count_q <= CntW'(Depth - 2));
  assign wr_ptr1     = ptr_inc(wr_ptr_q);

  // Advance pointers and count
  always_comb begin
    case (push_i.count)
      2'd1:    wr_ptr_d = wr_ptr1;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store results
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.second;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) + 32'(push_i.count)) <= (32'(Depth) + 32'(pop)))
    else $error("result queue overflow");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && count_q == CntW'(1) && push_i.count == 2'd0) |=> !out_valid_o)
    else $error("result queue shows a result after draining");

endmodule

>>> design/utf8_to_utf16_decoder_unit.sv
// UTF-8 to UTF-16 stream decoder, top level.
// Depends on u8u16_pkg, u8u16_step and u8u16_fifo.
//
// Takes one UTF-8 byte per request and returns UTF-16 code units, error
// reports and end-of-text markers. Each accepted byte is decoded
// combinationally against the state registers and its results land in a
// result queue (Depth entries, default 4) that feeds the output one result
// per cycle while out_ready_i is high. A byte may be accepted every cycle
// while the queue has room for two results, so the input runs at one byte
// per cycle; a byte that ends a sequence with a value from U+10000 to
// U+10FFFF yields a surrogate pair of two results, so the sustained rate
// is one result per cycle at the output.
module utf8_to_utf16_decoder_unit #(
  parameter int unsigned Depth = u8u16_pkg::FifoDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  u8u16_pkg::in_req_t   in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u8u16_pkg::out_rsp_t  out_rsp_o
);
  import u8u16_pkg::*;

  logic [PendW-1:0]  pend_q, pend_d, pend_s;
  logic [AccumW-1:0] accum_q, accum_d, accum_s;
  logic              disc_q, disc_d, disc_s;
  step_res_t         step_res, push;
  logic              accept;
  logic              space2;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = space2;

  u8u16_step u_step (
    .req_i   (in_req_i),
    .pend_i  (pend_q),
    .accum_i (accum_q),
    .disc_i  (disc_q),
    .pend_o  (pend_s),
    .accum_o (accum_s),
    .disc_o  (disc_s),
    .res_o   (step_res)
  );

  // Update state and push results only on an accepted request
  always_comb begin
    push = step_res;
    if (accept) begin
      pend_d  = pend_s;
      accum_d = accum_s;
      disc_d  = disc_s;
    end else begin
      pend_d     = pend_q;
      accum_d    = accum_q;
      disc_d     = disc_q;
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      accum_q <= '0;
      disc_q  <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      accum_q <= accum_d;
      disc_q  <= disc_d;
    end
  end

  u8u16_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space2_o    (space2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  a_disc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (pend_q == '0 && accum_q == '0))
    else $error("discarding with a sequence still pending");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MaxPending)
    else $error("pending count out of range");

  a_text_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.text_end) |=> (pend_q == '0 && !disc_q))
    else $error("state not cleared at end of text");

endmodule
